// ===== rtl/core/suf_pkg.sv =====
// shared types, codes and crc function for the register datagram framer
package suf_pkg;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_REPLY = 2'd2;

    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    localparam logic [2:0] READ_LAST_IDX  = 3'd3;
    localparam logic [2:0] WRITE_LAST_IDX = 3'd7;
    localparam logic [2:0] REPLY_LAST_IDX = 3'd7;
    localparam logic [2:0] REPLY_DATA_IDX = 3'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  node_address;
        logic [6:0]  register_address;
        logic [31:0] write_value;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last_byte;
        logic [31:0] read_data;
        logic        crc_error;
    } t_out_item;

    // one queued job: a request datagram or a finished read result
    typedef struct packed {
        logic        is_result;
        logic        is_write;
        logic [7:0]  node;
        logic [6:0]  reg_addr;
        logic [31:0] value;
        logic        crc_error;
    } t_cmd;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[7] ^ data[i]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/suf_front.sv =====
// front end: accepts items, tracks reply collection, queues jobs
module suf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  suf_pkg::t_in_item i_in_data,
    input  logic             i_q_full,
    output logic             o_push,
    output suf_pkg::t_cmd    o_push_data
);
    import suf_pkg::*;

    logic        r_pending;
    logic [2:0]  r_count;
    logic [7:0]  r_crc;
    logic [31:0] r_data;
    logic        accept;
    logic        is_final;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign is_final   = r_pending && (r_count == REPLY_LAST_IDX);

    always_comb begin
        o_push                = 1'b0;
        o_push_data.is_result = 1'b0;
        o_push_data.is_write  = (i_in_data.action == ACT_WRITE);
        o_push_data.node      = i_in_data.node_address;
        o_push_data.reg_addr  = i_in_data.register_address;
        o_push_data.value     = i_in_data.write_value;
        o_push_data.crc_error = 1'b0;
        if (accept) begin
            unique case (i_in_data.action) inside
                ACT_READ, ACT_WRITE: begin
                    o_push = 1'b1;
                end
                ACT_REPLY: begin
                    if (is_final) begin
                        o_push                = 1'b1;
                        o_push_data.is_result = 1'b1;
                        o_push_data.value     = r_data;
                        o_push_data.crc_error = (r_crc != i_in_data.rx_byte);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_count   <= '0;
            r_crc     <= '0;
            r_data    <= '0;
        end else if (accept) begin
            unique case (i_in_data.action)
                ACT_READ: begin
                    r_pending <= 1'b1;
                    r_count   <= '0;
                    r_crc     <= '0;
                    r_data    <= '0;
                end
                ACT_WRITE: begin
                    r_pending <= 1'b0;
                    r_count   <= '0;
                    r_crc     <= '0;
                    r_data    <= '0;
                end
                ACT_REPLY: begin
                    if (is_final) begin
                        r_pending <= 1'b0;
                        r_count   <= '0;
                        r_crc     <= '0;
                        r_data    <= '0;
                    end else if (r_pending) begin
                        r_crc   <= crc_feed(r_crc, i_in_data.rx_byte);
                        r_count <= r_count + 3'd1;
                        if (r_count >= REPLY_DATA_IDX) begin
                            r_data <= {r_data[23:0], i_in_data.rx_byte};
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/suf_queue.sv =====
// two-entry job queue between front and back
module suf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  suf_pkg::t_cmd i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output suf_pkg::t_cmd o_data
);
    import suf_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/suf_back.sv =====
// back end: serializes datagram bytes with crc and emits read results
module suf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  suf_pkg::t_cmd     i_q_data,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output suf_pkg::t_out_item o_out_data
);
    import suf_pkg::*;

    t_cmd      r_cmd;
    logic      r_busy;
    logic [2:0] r_idx;
    logic [7:0] r_crc;
    logic      r_out_valid;
    t_out_item r_out;

    logic      adv;
    logic      emit;
    logic      last;
    logic [7:0] data_byte;
    t_out_item n_out;

    assign adv  = !r_out_valid || !i_out_stall;
    assign emit = r_busy && adv;
    assign last = r_cmd.is_result ||
                  (r_idx == (r_cmd.is_write ? WRITE_LAST_IDX : READ_LAST_IDX));
    assign o_pop = i_q_valid && (!r_busy || (emit && last));

    always_comb begin
        case (r_idx)
            3'd0:    data_byte = SYNC_BYTE;
            3'd1:    data_byte = r_cmd.node;
            3'd2:    data_byte = {r_cmd.is_write, r_cmd.reg_addr};
            3'd3:    data_byte = r_cmd.value[31:24];
            3'd4:    data_byte = r_cmd.value[23:16];
            3'd5:    data_byte = r_cmd.value[15:8];
            default: data_byte = r_cmd.value[7:0];
        endcase
        if (r_cmd.is_result) begin
            n_out.kind      = KIND_RESULT;
            n_out.tx_byte   = '0;
            n_out.last_byte = 1'b0;
            n_out.read_data = r_cmd.value;
            n_out.crc_error = r_cmd.crc_error;
        end else begin
            n_out.kind      = KIND_TX;
            n_out.tx_byte   = last ? r_crc : data_byte;
            n_out.last_byte = last;
            n_out.read_data = '0;
            n_out.crc_error = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_data;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= emit;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_crc  <= '0;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 3'd1;
                r_crc <= crc_feed(r_crc, data_byte);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/stepper_uart_register_framer.sv =====
// top level of the register datagram framer
// path: each job passes the job queue, the command register and the output register
// throughput: one output transfer per cycle unless stalled; a write request is 8 bytes,
// a read 4; back-to-back datagrams leave no gap, set by the byte serializer
// reset: synchronous active low, clears queue, reply tracking and output valid
module stepper_uart_register_framer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  suf_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output suf_pkg::t_out_item o_out_data
);
    import suf_pkg::*;

    logic q_full;
    logic q_push;
    t_cmd q_push_data;
    logic q_pop;
    logic q_valid;
    t_cmd q_data;

    suf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    suf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    suf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
